@@ rtl/timer_heap_scheduler_top_assert.svh @@
// Assertion macros for the timer heap scheduler.
// Used by the top level only; needs a clock and an active-low reset name.
`ifndef TIMER_HEAP_SCHEDULER_TOP_ASSERT_SVH
`define TIMER_HEAP_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication
`define THS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define THS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ths_pkg.sv @@
// Shared types and codes for the timer heap scheduler.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none
package ths_pkg;

    localparam logic [1:0] REQ_ADD  = 2'd0;
    localparam logic [1:0] REQ_DEL  = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    localparam logic [1:0] RESP_ADD    = 2'd0;
    localparam logic [1:0] RESP_DEL    = 2'd1;
    localparam logic [1:0] RESP_EXPIRY = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_TOO_MANY = 2'd1;
    localparam logic [1:0] STAT_NO_TIMER = 2'd2;

    localparam int FLAG_PERIODIC = 0;
    localparam int FLAG_DELETED  = 1;

    localparam int RESULT_CAP = 16;
    localparam int NRES_W     = $clog2(RESULT_CAP + 1);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_ADD,
        OP_SU_RD,
        OP_SU_CMP,
        OP_DEL_RD,
        OP_DEL_CMP,
        OP_TICK,
        OP_POP_RD,
        OP_POP_TEST,
        OP_POP_LD,
        OP_SD_RD,
        OP_SD_CMP,
        OP_POST
    } t_op;

    typedef struct packed {
        logic full;
        logic hole_zero;
        logic par_gt;
        logic del_end;
        logic del_hit;
        logic pop_go;
        logic heap_empty;
        logic sd_move;
        logic top_periodic;
    } t_status;

endpackage
`default_nettype wire

@@ rtl/ths_ctrl.sv @@
// Sequencer for the timer heap scheduler: walks add, delete and tick requests
// through datapath micro-operations. Depends on ths_pkg.
`default_nettype none
module ths_ctrl
    import ths_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [1:0] i_req_type,
    input  wire t_status    i_st,
    output t_op             o_op,
    output logic            o_busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_SU_RD,
        S_SU_CMP,
        S_DEL_RD,
        S_DEL_CMP,
        S_TICK,
        S_POP_RD,
        S_POP_TEST,
        S_POP_LD,
        S_SD_RD,
        S_SD_CMP,
        S_POST
    } t_state;

    t_state r_state;
    logic   r_in_tick;

    always_comb begin
        case (r_state)
            S_IDLE:     o_op = i_start ? OP_LATCH : OP_NONE;
            S_ADD:      o_op = OP_ADD;
            S_SU_RD:    o_op = OP_SU_RD;
            S_SU_CMP:   o_op = OP_SU_CMP;
            S_DEL_RD:   o_op = OP_DEL_RD;
            S_DEL_CMP:  o_op = OP_DEL_CMP;
            S_TICK:     o_op = OP_TICK;
            S_POP_RD:   o_op = OP_POP_RD;
            S_POP_TEST: o_op = OP_POP_TEST;
            S_POP_LD:   o_op = OP_POP_LD;
            S_SD_RD:    o_op = OP_SD_RD;
            S_SD_CMP:   o_op = OP_SD_CMP;
            S_POST:     o_op = OP_POST;
            default:    o_op = OP_NONE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_in_tick <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        case (i_req_type)
                            REQ_ADD:  r_state <= S_ADD;
                            REQ_DEL:  r_state <= S_DEL_RD;
                            REQ_TICK: r_state <= S_TICK;
                            default:  r_state <= S_IDLE;
                        endcase
                    end
                end
                S_ADD: begin
                    r_in_tick <= 1'b0;
                    r_state   <= i_st.full ? S_IDLE : S_SU_RD;
                end
                S_SU_RD: begin
                    if (i_st.hole_zero) begin
                        r_state <= r_in_tick ? S_POP_RD : S_IDLE;
                    end else begin
                        r_state <= S_SU_CMP;
                    end
                end
                S_SU_CMP: begin
                    if (i_st.par_gt) begin
                        r_state <= S_SU_RD;
                    end else begin
                        r_state <= r_in_tick ? S_POP_RD : S_IDLE;
                    end
                end
                S_DEL_RD:   r_state <= i_st.del_end ? S_IDLE : S_DEL_CMP;
                S_DEL_CMP:  r_state <= i_st.del_hit ? S_IDLE : S_DEL_RD;
                S_TICK: begin
                    r_in_tick <= 1'b1;
                    r_state   <= S_POP_RD;
                end
                S_POP_RD:   r_state <= S_POP_TEST;
                S_POP_TEST: r_state <= i_st.pop_go ? S_POP_LD : S_IDLE;
                S_POP_LD:   r_state <= i_st.heap_empty ? S_POST : S_SD_RD;
                S_SD_RD:    r_state <= S_SD_CMP;
                S_SD_CMP:   r_state <= i_st.sd_move ? S_SD_RD : S_POST;
                S_POST:     r_state <= i_st.top_periodic ? S_SU_RD : S_POP_RD;
                default:    r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/ths_dp.sv @@
// Datapath for the timer heap scheduler: heap memory, sift hole registers,
// id allocation, tick counter and result registers. Depends on ths_pkg.
`default_nettype none
module ths_dp
    import ths_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_op         i_op,
    input  wire logic [31:0] i_duration,
    input  wire logic        i_periodic,
    input  wire logic [3:0]  i_target_id,
    output t_status          o_st,
    output logic             o_strobe,
    output logic [1:0]       o_resp_kind,
    output logic [3:0]       o_timer_id,
    output logic [1:0]       o_status,
    output logic             o_last
);

    localparam int IW   = $clog2(NUM_TIMERS);
    localparam int CW   = $clog2(NUM_TIMERS + 1);
    localparam int AW   = IW + 2;
    localparam int CMPW = (IW > 4) ? IW : 4;

    typedef struct packed {
        logic [31:0]   dl;
        logic [31:0]   per;
        logic [1:0]    fl;
        logic [IW-1:0] own;
    } t_entry;

    t_entry mem [NUM_TIMERS];

    t_entry            r_rd_a, r_rd_b, r_e, n_e, r_top, n_top;
    logic [IW-1:0]     ra_a, ra_b, wa;
    t_entry            wd;
    logic              we;

    logic [31:0]       r_now, n_now, r_dur, n_dur;
    logic              r_prd, n_prd;
    logic [3:0]        r_tgt, n_tgt;
    logic [CW-1:0]     r_count, n_count, r_scan, n_scan, r_pops, n_pops;
    logic [IW-1:0]     r_hole, n_hole;
    logic [NUM_TIMERS-1:0] r_inuse, n_inuse;
    logic [NRES_W-1:0] r_nres, n_nres;
    logic              r_pend, n_pend;
    logic [IW-1:0]     r_pend_id, n_pend_id;
    logic              r_stb, n_stb, r_last, n_last;
    logic [1:0]        r_kind, n_kind, r_stat, n_stat;
    logic [3:0]        r_id, n_id;

    logic              free_ok;
    logic [IW-1:0]     free_id;
    logic [AW-1:0]     lc, rc;
    logic              l_lt, r_lt;
    logic [31:0]       best_dl;

    always_comb begin
        free_ok = 1'b0;
        free_id = '0;
        for (int k = NUM_TIMERS - 1; k >= 0; k--) begin
            if (!r_inuse[k]) begin
                free_ok = 1'b1;
                free_id = IW'(k);
            end
        end
    end

    assign lc      = (AW'(r_hole) << 1) + AW'(1);
    assign rc      = lc + AW'(1);
    assign l_lt    = (lc < AW'(r_count)) && (r_rd_a.dl < r_e.dl);
    assign best_dl = l_lt ? r_rd_a.dl : r_e.dl;
    assign r_lt    = (rc < AW'(r_count)) && (r_rd_b.dl < best_dl);

    always_comb begin
        o_st.full         = !free_ok || (r_count >= CW'(NUM_TIMERS));
        o_st.hole_zero    = (r_hole == '0);
        o_st.par_gt       = (r_rd_a.dl > r_e.dl);
        o_st.del_end      = (r_scan >= r_count);
        o_st.del_hit      = (CMPW'(r_rd_a.own) == CMPW'(r_tgt));
        o_st.pop_go       = (r_count != '0) && (r_rd_a.dl <= r_now)
                            && (r_pops < CW'(NUM_TIMERS))
                            && (r_nres < NRES_W'(RESULT_CAP));
        o_st.heap_empty   = (r_count == '0);
        o_st.sd_move      = l_lt || r_lt;
        o_st.top_periodic = r_top.fl[FLAG_PERIODIC];
    end

    always_comb begin
        t_entry w_tmp;
        w_tmp     = r_rd_a;
        n_e       = r_e;
        n_top     = r_top;
        n_now     = r_now;
        n_dur     = r_dur;
        n_prd     = r_prd;
        n_tgt     = r_tgt;
        n_count   = r_count;
        n_scan    = r_scan;
        n_pops    = r_pops;
        n_hole    = r_hole;
        n_inuse   = r_inuse;
        n_nres    = r_nres;
        n_pend    = r_pend;
        n_pend_id = r_pend_id;
        n_stb     = 1'b0;
        n_last    = r_last;
        n_kind    = r_kind;
        n_stat    = r_stat;
        n_id      = r_id;
        ra_a      = '0;
        ra_b      = '0;
        we        = 1'b0;
        wa        = r_hole;
        wd        = r_e;
        case (i_op)
            OP_LATCH: begin
                n_dur  = i_duration;
                n_prd  = i_periodic;
                n_tgt  = i_target_id;
                n_scan = '0;
            end
            OP_ADD: begin
                n_stb  = 1'b1;
                n_kind = RESP_ADD;
                n_last = 1'b1;
                if (o_st.full) begin
                    n_stat = STAT_TOO_MANY;
                    n_id   = '0;
                end else begin
                    n_e.dl   = r_now + r_dur;
                    n_e.per  = r_dur;
                    n_e.fl   = '0;
                    n_e.fl[FLAG_PERIODIC] = r_prd;
                    n_e.own  = free_id;
                    n_hole   = IW'(r_count);
                    n_count  = r_count + CW'(1);
                    n_inuse[free_id] = 1'b1;
                    n_stat   = STAT_OK;
                    n_id     = 4'(free_id);
                end
            end
            OP_SU_RD: begin
                ra_a = (r_hole - IW'(1)) >> 1;
                if (r_hole == '0) begin
                    we = 1'b1;
                end
            end
            OP_SU_CMP: begin
                we = 1'b1;
                if (o_st.par_gt) begin
                    wd     = r_rd_a;
                    n_hole = (r_hole - IW'(1)) >> 1;
                end
            end
            OP_DEL_RD: begin
                ra_a = IW'(r_scan);
                if (o_st.del_end) begin
                    n_stb  = 1'b1;
                    n_kind = RESP_DEL;
                    n_id   = r_tgt;
                    n_stat = STAT_NO_TIMER;
                    n_last = 1'b1;
                end
            end
            OP_DEL_CMP: begin
                if (o_st.del_hit) begin
                    w_tmp.fl[FLAG_DELETED]  = 1'b1;
                    w_tmp.fl[FLAG_PERIODIC] = 1'b0;
                    we     = 1'b1;
                    wa     = IW'(r_scan);
                    wd     = w_tmp;
                    n_stb  = 1'b1;
                    n_kind = RESP_DEL;
                    n_id   = r_tgt;
                    n_stat = STAT_OK;
                    n_last = 1'b1;
                end else begin
                    n_scan = r_scan + CW'(1);
                end
            end
            OP_TICK: begin
                n_now  = r_now + 32'd1;
                n_pops = '0;
                n_nres = '0;
                n_pend = 1'b0;
            end
            OP_POP_RD: begin
                ra_a = '0;
            end
            OP_POP_TEST: begin
                if (o_st.pop_go) begin
                    n_top   = r_rd_a;
                    n_count = r_count - CW'(1);
                    n_pops  = r_pops + CW'(1);
                    ra_a    = IW'(r_count - CW'(1));
                end else if (r_pend) begin
                    n_stb  = 1'b1;
                    n_kind = RESP_EXPIRY;
                    n_id   = 4'(r_pend_id);
                    n_stat = STAT_OK;
                    n_last = 1'b1;
                    n_pend = 1'b0;
                end
            end
            OP_POP_LD: begin
                n_e    = r_rd_a;
                n_hole = '0;
            end
            OP_SD_RD: begin
                ra_a = IW'(lc);
                ra_b = IW'(rc);
            end
            OP_SD_CMP: begin
                we = 1'b1;
                if (r_lt) begin
                    wd     = r_rd_b;
                    n_hole = IW'(rc);
                end else if (l_lt) begin
                    wd     = r_rd_a;
                    n_hole = IW'(lc);
                end
            end
            OP_POST: begin
                if (!r_top.fl[FLAG_DELETED]) begin
                    if (r_pend) begin
                        n_stb  = 1'b1;
                        n_kind = RESP_EXPIRY;
                        n_id   = 4'(r_pend_id);
                        n_stat = STAT_OK;
                        n_last = 1'b0;
                    end
                    n_pend    = 1'b1;
                    n_pend_id = r_top.own;
                    n_nres    = r_nres + NRES_W'(1);
                end
                if (r_top.fl[FLAG_PERIODIC]) begin
                    n_e        = r_top;
                    n_e.dl     = r_top.dl + r_top.per;
                    n_hole     = IW'(r_count);
                    n_count    = r_count + CW'(1);
                end else begin
                    n_inuse[r_top.own] = 1'b0;
                end
            end
            default: begin
                n_stb = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd_a <= mem[ra_a];
        r_rd_b <= mem[ra_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now   <= '0;
            r_count <= '0;
            r_inuse <= '0;
            r_pend  <= 1'b0;
            r_stb   <= 1'b0;
            r_nres  <= '0;
            r_pops  <= '0;
            r_scan  <= '0;
            r_hole  <= '0;
        end else begin
            r_now   <= n_now;
            r_count <= n_count;
            r_inuse <= n_inuse;
            r_pend  <= n_pend;
            r_stb   <= n_stb;
            r_nres  <= n_nres;
            r_pops  <= n_pops;
            r_scan  <= n_scan;
            r_hole  <= n_hole;
        end
        r_e       <= n_e;
        r_top     <= n_top;
        r_dur     <= n_dur;
        r_prd     <= n_prd;
        r_tgt     <= n_tgt;
        r_pend_id <= n_pend_id;
        r_last    <= n_last;
        r_kind    <= n_kind;
        r_stat    <= n_stat;
        r_id      <= n_id;
    end

    assign o_strobe    = r_stb;
    assign o_resp_kind = r_kind;
    assign o_timer_id  = r_id;
    assign o_status    = r_stat;
    assign o_last      = r_last;

endmodule
`default_nettype wire

@@ rtl/timer_heap_scheduler_top.sv @@
// Timer heap scheduler top level: sequencer plus heap datapath.
// Depends on ths_pkg, ths_ctrl, ths_dp and timer_heap_scheduler_top_assert.svh.
// Requests are taken when start is high and busy is low; one request at a time.
// Each result beat is on the o_ ports for one cycle, marked by o_strobe, and
// cannot be held off by the receiver. An add allocates a free id and then sifts
// the new timer up by parent compares; a refused add sifts nothing. A delete
// searches the heap slots in order for the id. A tick advances the time, then
// pops expired timers and sifts each hole down by child compares (none when
// the pop empties the heap); a periodic timer is put back with a new deadline
// and sifted up. All heap moves go through one dual-read, single-write memory.
`default_nettype none
`include "timer_heap_scheduler_top_assert.svh"
module timer_heap_scheduler_top
    import ths_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [31:0] i_duration,
    input  wire logic        i_periodic,
    input  wire logic [3:0]  i_target_id,
    output logic             o_strobe,
    output logic [1:0]       o_resp_kind,
    output logic [3:0]       o_timer_id,
    output logic [1:0]       o_status,
    output logic             o_last
);

    t_op     op;
    t_status st;
    logic    req_known;

    assign req_known = (i_req_type == REQ_ADD) || (i_req_type == REQ_DEL)
                       || (i_req_type == REQ_TICK);

    ths_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_st       (st),
        .o_op       (op),
        .o_busy     (busy)
    );

    ths_dp #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_duration  (i_duration),
        .i_periodic  (i_periodic),
        .i_target_id (i_target_id),
        .o_st        (st),
        .o_strobe    (o_strobe),
        .o_resp_kind (o_resp_kind),
        .o_timer_id  (o_timer_id),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    `THS_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n,
        start && !busy && req_known, busy, "request not taken up")
    `THS_ASSERT_NXT(a_gap_after_last, i_clk, i_rst_n,
        o_strobe && o_last, !o_strobe, "beat straight after final beat")
    `THS_ASSERT_IMP(a_only_expiry_chains, i_clk, i_rst_n,
        o_strobe && !o_last, o_resp_kind == RESP_EXPIRY, "non-final beat that is not an expiry")

endmodule
`default_nettype wire
